>>> rtl/wob_pkg.sv
// Shared constants, codes and controller/datapath interface types for the oscillator.
`timescale 1ns / 1ps
`default_nettype none

package wob_pkg;

   // Wavetable geometry (power of two; tables are built from it at elaboration)
   localparam int TABLE_LEN      = 1024;
   localparam int TABLE_BITS     = $clog2(TABLE_LEN);
   localparam int HALF_LEN       = TABLE_LEN / 2;
   localparam int QUARTER_LEN    = TABLE_LEN / 4;
   localparam int SINE_ROM_DEPTH = QUARTER_LEN + 1;
   localparam int SINE_ADDR_W    = $clog2(SINE_ROM_DEPTH);
   localparam int ROM_W          = 15;

   // Datapath widths
   localparam int SAMPLE_W   = 16;
   localparam int COEF_W     = 16;
   localparam int Y_W        = 18;
   localparam int ACC_W      = 36;
   localparam int MUL_A_W    = 19;
   localparam int MUL_B_W    = 32;
   localparam int PROD_W     = MUL_A_W + MUL_B_W;
   localparam int GAIN_W     = 31;
   localparam int MAG_W      = 18;
   localparam int STEP_W     = 10;
   localparam int SEL_W      = 2;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 16;

   localparam logic [SAMPLE_W-1:0] UNITY_Q15 = 16'd32768;

   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_WAVEFORM_SELECT = 3'd0,
      REG_PHASE_STEP      = 3'd1,
      REG_VOLUME          = 3'd2,
      REG_FEED_COEF_0     = 3'd3,
      REG_FEED_COEF_1     = 3'd4,
      REG_FEED_COEF_2     = 3'd5,
      REG_BACK_COEF_1     = 3'd6,
      REG_BACK_COEF_2     = 3'd7
   } reg_index_type;

   typedef enum logic [SEL_W-1:0] {
      WAVE_SINE     = 2'd0,
      WAVE_SAW      = 2'd1,
      WAVE_SQUARE   = 2'd2,
      WAVE_TRIANGLE = 2'd3
   } wave_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_WAVE,
      ST_M0,
      ST_M1,
      ST_M2,
      ST_M3,
      ST_M4,
      ST_ACC,
      ST_ROUND,
      ST_SCALE,
      ST_OUT
   } state_type;

   typedef enum logic [2:0] {
      MUL_GAIN,
      MUL_F0X,
      MUL_F1X1,
      MUL_F2X2,
      MUL_B1Y1,
      MUL_B2Y2,
      MUL_SCALE
   } mul_src_type;

   typedef enum logic [1:0] {
      ACC_HOLD,
      ACC_LOAD,
      ACC_ADD,
      ACC_SUB
   } acc_op_type;

   typedef struct packed {
      logic        capture;
      logic        wave_load;
      logic        mul_en;
      mul_src_type mul_src;
      acc_op_type  acc_op;
      logic        gain_load;
      logic        y_load;
      logic        out_load;
      logic        commit;
   } wob_cmd_type;

   typedef struct packed {
      logic out_free;
   } wob_status_type;

endpackage

`default_nettype wire

>>> rtl/wavetable_oscillator_biquad.sv
// Top level of the wavetable oscillator with biquad filter and volume/envelope scaling.
`timescale 1ns / 1ps
`default_nettype none

// Each beat accepted on req_ is one sample tick: it reads the selected waveform
// (sine, saw, square, triangle) at the current phase, filters it with a direct-form-I
// biquad (Q2.14 coefficients, Q3.15 output saturated to 18 bits), scales it by
// volume times envelope, saturates to int16 and emits one beat on rsp_; then the
// phase advances by phase_step modulo the 1024-entry table. One tick runs through
// the accept step (which also reads the quarter-wave sine ROM), then ten sequencer
// steps through the single 19x32 shared multiplier (gain, five filter taps, final
// scale) plus rounding and output. The next tick is taken the cycle after the
// result enters the output register, while that result waits for rsp_tready. The
// user must write configuration through csr_ only while no tick is in flight; the
// block itself does not enforce this, and there is no read-back.

module wavetable_oscillator_biquad
   import wob_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   // configuration write port
   input  wire logic                   csr_we,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_wdata,
   // sample tick input
   input  wire logic                   req_tvalid,
   output logic                        req_tready,
   input  wire logic [15:0]            req_tdata,   // [15:0] envelope_gain
   input  wire logic                   req_tlast,   // buffer_last
   // audio sample output
   output logic                        rsp_tvalid,
   input  wire logic                   rsp_tready,
   output logic [15:0]                 rsp_tdata,   // [15:0] sample_out
   output logic                        rsp_tlast    // sample_last
);

   wob_cmd_type    cmd;
   wob_status_type status;

   // Sequencer: one tick at a time, stalls in its last step on a full output
   wob_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   // Datapath: configuration, ROM, multiplier, filter history and output beat
   wob_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .cmd        (cmd),
      .status     (status)
   );

`ifndef SYNTH
   // An accepted tick makes the block busy on the next cycle
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("input accepted again right after a tick was taken");

   // A result is only loaded into a free output slot, so no beat is overwritten
   a_load_into_free: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> (!rsp_tvalid || rsp_tready))
      else $error("output register overwritten while a beat was pending");

   // A loaded result shows up as a valid beat in the next cycle
   a_load_shows: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |=> rsp_tvalid)
      else $error("loaded result not presented on rsp");
`endif

endmodule

`default_nettype wire

>>> rtl/wob_ctrl.sv
// Sequencer that steps one sample tick through the shared-multiplier datapath.
`timescale 1ns / 1ps
`default_nettype none

module wob_ctrl
   import wob_pkg::*;
(
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           req_tvalid,
   output logic                req_tready,
   input  wire wob_status_type status,
   output wob_cmd_type         cmd
);

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in       = state_ff;
      req_tready     = 1'b0;
      cmd            = '0;
      cmd.mul_src    = MUL_GAIN;
      cmd.acc_op     = ACC_HOLD;
      unique case (state_ff)
         ST_IDLE: begin
            // refuse beats while reset is held
            req_tready = !reset;
            if (req_tvalid && !reset) begin
               cmd.capture = 1'b1;
               state_in    = ST_WAVE;
            end
         end
         ST_WAVE: begin
            cmd.wave_load = 1'b1;
            cmd.mul_en    = 1'b1;
            cmd.mul_src   = MUL_GAIN;
            state_in      = ST_M0;
         end
         ST_M0: begin
            cmd.gain_load = 1'b1;
            cmd.mul_en    = 1'b1;
            cmd.mul_src   = MUL_F0X;
            state_in      = ST_M1;
         end
         ST_M1: begin
            cmd.acc_op  = ACC_LOAD;
            cmd.mul_en  = 1'b1;
            cmd.mul_src = MUL_F1X1;
            state_in    = ST_M2;
         end
         ST_M2: begin
            cmd.acc_op  = ACC_ADD;
            cmd.mul_en  = 1'b1;
            cmd.mul_src = MUL_F2X2;
            state_in    = ST_M3;
         end
         ST_M3: begin
            cmd.acc_op  = ACC_ADD;
            cmd.mul_en  = 1'b1;
            cmd.mul_src = MUL_B1Y1;
            state_in    = ST_M4;
         end
         ST_M4: begin
            cmd.acc_op  = ACC_SUB;
            cmd.mul_en  = 1'b1;
            cmd.mul_src = MUL_B2Y2;
            state_in    = ST_ACC;
         end
         ST_ACC: begin
            cmd.acc_op = ACC_SUB;
            state_in   = ST_ROUND;
         end
         ST_ROUND: begin
            cmd.y_load = 1'b1;
            state_in   = ST_SCALE;
         end
         ST_SCALE: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_src = MUL_SCALE;
            state_in    = ST_OUT;
         end
         ST_OUT: begin
            // hold here while the previous beat still sits unclaimed
            if (status.out_free) begin
               cmd.out_load = 1'b1;
               cmd.commit   = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

>>> rtl/wob_datapath.sv
// Registers, wavetable ROM, shared multiplier, biquad accumulator and output stage.
`timescale 1ns / 1ps
`default_nettype none

module wob_datapath
   import wob_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   csr_we,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_wdata,
   input  wire logic [SAMPLE_W-1:0]    req_tdata,
   input  wire logic                   req_tlast,
   output logic                        rsp_tvalid,
   input  wire logic                   rsp_tready,
   output logic [SAMPLE_W-1:0]         rsp_tdata,
   output logic                        rsp_tlast,
   input  wire wob_cmd_type            cmd,
   output wob_status_type              status
);

   localparam logic [63:0] HALF_PI_Q29 = 64'd843314857;
   localparam logic [63:0] ONE_Q29     = 64'd536870912;
   localparam logic [7:0][7:0] SERIES_DIV =
      {8'd210, 8'd156, 8'd110, 8'd72, 8'd42, 8'd20, 8'd6, 8'd1};
   localparam int SAW_SHIFT = 16 - TABLE_BITS;
   localparam int TRI_SHIFT = 17 - TABLE_BITS;

   typedef logic [SINE_ROM_DEPTH-1:0][ROM_W-1:0] sine_rom_type;

   // Quarter-wave sine, odd Taylor series in Q29, rounded half up to Q15
   function automatic sine_rom_type build_sine_rom();
      sine_rom_type rom;
      logic [63:0]  x;
      logic [63:0]  x2;
      logic [63:0]  t;
      logic [63:0]  s;
      rom = '0;
      for (int q = 0; q < SINE_ROM_DEPTH; q++) begin
         x  = (64'(q) * 64'd4 * HALF_PI_Q29) / TABLE_LEN;
         x2 = (x * x) >> 29;
         t  = ONE_Q29;
         for (int k = 7; k >= 1; k--) begin
            t = ONE_Q29 - ((x2 * t) >> 29) / 64'(SERIES_DIV[k]);
         end
         s = (x * t) >> 29;
         s = (s + 64'd8192) >> 14;
         if (s > 64'd32767) begin
            s = 64'd32767;
         end
         rom[q] = s[ROM_W-1:0];
      end
      return rom;
   endfunction

   localparam sine_rom_type SINE_ROM = build_sine_rom();

   // Configuration
   logic [SEL_W-1:0]         wave_sel_ff;
   logic [STEP_W-1:0]        phase_step_ff;
   logic [SAMPLE_W-1:0]      volume_ff;
   logic signed [COEF_W-1:0] f0_ff, f1_ff, f2_ff, b1_ff, b2_ff;

   // Tick state
   logic [TABLE_BITS-1:0]      phase_ff;
   logic signed [SAMPLE_W-1:0] x1_ff, x2_ff;
   logic signed [Y_W-1:0]      y1_ff, y2_ff;

   // Per-item working registers
   logic [SAMPLE_W-1:0]        env_ff;
   logic                       last_ff;
   logic [ROM_W-1:0]           rom_q_ff;
   logic signed [SAMPLE_W-1:0] x_ff;
   logic signed [PROD_W-1:0]   prod_ff;
   logic [GAIN_W-1:0]          gain_ff;
   logic signed [ACC_W-1:0]    acc_ff;
   logic signed [Y_W-1:0]      y_ff;
   logic                       rsp_valid_ff;
   logic [SAMPLE_W-1:0]        rsp_data_ff;
   logic                       rsp_last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         wave_sel_ff   <= WAVE_SINE;
         phase_step_ff <= STEP_W'(1);
         volume_ff     <= UNITY_Q15;
         f0_ff         <= 16'sd16384;
         f1_ff         <= '0;
         f2_ff         <= '0;
         b1_ff         <= '0;
         b2_ff         <= '0;
      end else if (csr_we) begin
         unique case (reg_index_type'(csr_index))
            REG_WAVEFORM_SELECT: wave_sel_ff   <= csr_wdata[SEL_W-1:0];
            REG_PHASE_STEP:      phase_step_ff <= csr_wdata[STEP_W-1:0];
            REG_VOLUME:          volume_ff     <= csr_wdata;
            REG_FEED_COEF_0:     f0_ff         <= csr_wdata;
            REG_FEED_COEF_1:     f1_ff         <= csr_wdata;
            REG_FEED_COEF_2:     f2_ff         <= csr_wdata;
            REG_BACK_COEF_1:     b1_ff         <= csr_wdata;
            REG_BACK_COEF_2:     b2_ff         <= csr_wdata;
         endcase
      end
   end

   // Quarter-wave fold of the phase for the sine ROM
   logic [TABLE_BITS-2:0]  half_idx;
   logic [TABLE_BITS-1:0]  fold_idx;
   logic [SINE_ADDR_W-1:0] rom_addr;

   always_comb begin
      half_idx = phase_ff[TABLE_BITS-2:0];
      if (TABLE_BITS'(half_idx) > TABLE_BITS'(QUARTER_LEN)) begin
         fold_idx = TABLE_BITS'(HALF_LEN) - TABLE_BITS'(half_idx);
      end else begin
         fold_idx = TABLE_BITS'(half_idx);
      end
      rom_addr = fold_idx[SINE_ADDR_W-1:0];
   end

   logic [SAMPLE_W-1:0] env_sat;
   assign env_sat = (req_tdata > UNITY_Q15) ? UNITY_Q15 : req_tdata;

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         rom_q_ff <= SINE_ROM[rom_addr];
         env_ff   <= env_sat;
         last_ff  <= req_tlast;
      end
   end

   // Waveform value
   logic signed [Y_W:0]        saw_full;
   logic signed [Y_W:0]        ramp;
   logic signed [Y_W:0]        tri_full;
   logic signed [SAMPLE_W-1:0] wave_val;
   logic                       lower_half;

   always_comb begin
      lower_half = (phase_ff < TABLE_BITS'(HALF_LEN));
      saw_full   = $signed((Y_W+1)'(phase_ff) << SAW_SHIFT) - 19'sd32768;
      ramp       = $signed((Y_W+1)'(phase_ff) << TRI_SHIFT);
      tri_full   = lower_half ? (ramp - 19'sd32768) : (19'sd98304 - ramp);
      if (tri_full > 19'sd32767) begin
         tri_full = 19'sd32767;
      end else if (tri_full < -19'sd32768) begin
         tri_full = -19'sd32768;
      end
      case (wave_type'(wave_sel_ff))
         WAVE_SINE: begin
            if (phase_ff[TABLE_BITS-1]) begin
               wave_val = -$signed({1'b0, rom_q_ff});
            end else begin
               wave_val = $signed({1'b0, rom_q_ff});
            end
         end
         WAVE_SAW:      wave_val = saw_full[SAMPLE_W-1:0];
         WAVE_SQUARE:   wave_val = lower_half ? 16'sd32767 : -16'sd32768;
         WAVE_TRIANGLE: wave_val = tri_full[SAMPLE_W-1:0];
         default:       wave_val = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.wave_load) begin
         x_ff <= wave_val;
      end
   end

   // Shared multiplier operand select
   logic [SAMPLE_W-1:0]         vol_sat;
   logic [MAG_W-1:0]            mag;
   logic signed [MUL_A_W-1:0]   mul_a;
   logic signed [MUL_B_W-1:0]   mul_b;

   assign vol_sat = (volume_ff > UNITY_Q15) ? UNITY_Q15 : volume_ff;
   assign mag     = y_ff[Y_W-1] ? MAG_W'(-y_ff) : MAG_W'(y_ff);

   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (cmd.mul_src)
         MUL_GAIN: begin
            mul_a = $signed({3'b000, vol_sat});
            mul_b = $signed({16'd0, env_ff});
         end
         MUL_F0X: begin
            mul_a = MUL_A_W'(x_ff);
            mul_b = MUL_B_W'(f0_ff);
         end
         MUL_F1X1: begin
            mul_a = MUL_A_W'(x1_ff);
            mul_b = MUL_B_W'(f1_ff);
         end
         MUL_F2X2: begin
            mul_a = MUL_A_W'(x2_ff);
            mul_b = MUL_B_W'(f2_ff);
         end
         MUL_B1Y1: begin
            mul_a = MUL_A_W'(y1_ff);
            mul_b = MUL_B_W'(b1_ff);
         end
         MUL_B2Y2: begin
            mul_a = MUL_A_W'(y2_ff);
            mul_b = MUL_B_W'(b2_ff);
         end
         MUL_SCALE: begin
            mul_a = $signed({1'b0, mag});
            mul_b = $signed({1'b0, gain_ff});
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.mul_en) begin
         prod_ff <= mul_a * mul_b;
      end
      if (cmd.gain_load) begin
         gain_ff <= prod_ff[GAIN_W-1:0];
      end
   end

   // Biquad accumulator
   always_ff @(posedge clock) begin
      case (cmd.acc_op)
         ACC_LOAD: acc_ff <= ACC_W'(prod_ff);
         ACC_ADD:  acc_ff <= acc_ff + ACC_W'(prod_ff);
         ACC_SUB:  acc_ff <= acc_ff - ACC_W'(prod_ff);
         default:  acc_ff <= acc_ff;
      endcase
   end

   // Round half up to Q3.15 and saturate to 18 bits
   logic signed [ACC_W-1:0] rnd_sum;
   logic signed [ACC_W-1:0] rnd_shift;
   logic signed [Y_W-1:0]   y_sat;

   always_comb begin
      rnd_sum   = acc_ff + 36'sd8192;
      rnd_shift = rnd_sum >>> 14;
      if (rnd_shift > 36'sd131071) begin
         y_sat = 18'sd131071;
      end else if (rnd_shift < -36'sd131072) begin
         y_sat = -18'sd131072;
      end else begin
         y_sat = rnd_shift[Y_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.y_load) begin
         y_ff <= y_sat;
      end
   end

   // Output scaling: |y| * gain * 32767 / 2^45, sign restored, int16 saturate
   logic [47:0]         scale_prod;
   logic [63:0]         scale_wide;
   logic [18:0]         scaled;
   logic [SAMPLE_W-1:0] sample_val;

   always_comb begin
      scale_prod = prod_ff[47:0];
      scale_wide = (64'(scale_prod) << 15) - 64'(scale_prod);
      scaled     = scale_wide[63:45];
      if (y_ff[Y_W-1]) begin
         if (scaled > 19'd32768) begin
            sample_val = 16'h8000;
         end else begin
            sample_val = SAMPLE_W'(-scaled);
         end
      end else begin
         if (scaled > 19'd32767) begin
            sample_val = 16'h7FFF;
         end else begin
            sample_val = scaled[SAMPLE_W-1:0];
         end
      end
   end

   // Filter history and phase advance
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= '0;
         x1_ff    <= '0;
         x2_ff    <= '0;
         y1_ff    <= '0;
         y2_ff    <= '0;
      end else if (cmd.commit) begin
         phase_ff <= phase_ff + TABLE_BITS'(phase_step_ff);
         x2_ff    <= x1_ff;
         x1_ff    <= x_ff;
         y2_ff    <= y1_ff;
         y1_ff    <= y_ff;
      end
   end

   // Output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         rsp_data_ff <= sample_val;
         rsp_last_ff <= last_ff;
      end
   end

   assign rsp_tvalid      = rsp_valid_ff;
   assign rsp_tdata       = rsp_data_ff;
   assign rsp_tlast       = rsp_last_ff;
   assign status.out_free = !rsp_valid_ff || rsp_tready;

endmodule

`default_nettype wire

>>> dv/tb.sv
// Self-checking testbench for the wavetable oscillator with biquad filter.
`timescale 1ns / 1ps

module tb;
   import wob_pkg::*;

   localparam int unsigned RUN_LIMIT      = 400000;
   localparam int unsigned RANDOM_TICKS   = 420;
   localparam int unsigned SQUEEZE_CYCLES = 300;
   localparam int unsigned DRAIN_CYCLES   = 30;
   localparam longint unsigned HALF_PI_Q29 = 64'd843314857;
   localparam longint unsigned ONE_Q29     = 64'd536870912;

   typedef struct packed {
      logic [15:0] sample;
      logic        last;
   } tone_beat_type;

   typedef enum {ROW_TICK, ROW_CSR} row_kind_type;

   // One line of the directed script: either a register write or a tick.
   // A tick may carry a hand-typed expected sample where it is obvious.
   typedef struct {
      row_kind_type  kind;
      reg_index_type reg_sel;
      logic [15:0]   value;
      logic          last;
      bit            typed;
      logic [15:0]   want;
   } stim_row_type;

   logic                   clock;
   logic                   reset;
   logic                   csr_we;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;
   logic                   req_tvalid;
   logic                   req_tready;
   logic [15:0]            req_tdata;   // [15:0] envelope_gain
   logic                   req_tlast;   // buffer_last
   logic                   rsp_tvalid;
   logic                   rsp_tready;
   logic [15:0]            rsp_tdata;   // [15:0] sample_out
   logic                   rsp_tlast;   // sample_last

   // Shadow copy of the oscillator: configuration and filter/phase state
   wave_type    wave_sel;
   int unsigned step_size;
   logic [15:0] vol_q15;
   longint      feed [3];
   longint      back [2];
   int unsigned phase;
   longint      x_d1, x_d2, y_d1, y_d2;

   tone_beat_type expected_samples [$];
   stim_row_type  script [$];
   int unsigned   fail_count;
   int unsigned   cycle_count;

   // Traffic shaping shared by the sender and the receiver
   bit          calm;
   bit          squeeze_pending;

   wavetable_oscillator_biquad DUT (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   initial clock = 1'b0;
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ---------------------------------------------------------------------
   // Predictor
   // ---------------------------------------------------------------------

   function automatic longint clamp(longint v, longint lo, longint hi);
      return (v < lo) ? lo : ((v > hi) ? hi : v);
   endfunction

   // Quarter-wave fixed-point sine: angle in Q29, odd series up to x^15,
   // rounded half up to Q15 and capped at 32767.
   function automatic longint sine_lookup(int unsigned pos);
      longint unsigned a, x, x2, t, s, d;
      bit neg;
      a   = 64'(pos) * 4;
      neg = 1'b0;
      if (a >= 2 * TABLE_LEN) begin
         neg = 1'b1;
         a   = a - 2 * TABLE_LEN;
      end
      if (a > TABLE_LEN)
         a = 2 * TABLE_LEN - a;
      x  = a * HALF_PI_Q29 / TABLE_LEN;
      x2 = (x * x) >> 29;
      t  = ONE_Q29;
      for (int k = 7; k >= 1; k--) begin
         d = 64'(2 * k) * 64'(2 * k + 1);
         t = ONE_Q29 - ((x2 * t) >> 29) / d;
      end
      s = (x * t) >> 29;
      s = (s + 64'd8192) >> 14;
      if (s > 64'd32767)
         s = 64'd32767;
      return neg ? -longint'(s) : longint'(s);
   endfunction

   function automatic longint wave_lookup(wave_type sel, int unsigned pos);
      longint p;
      longint v;
      p = longint'(pos);
      case (sel)
         WAVE_SINE:   v = sine_lookup(pos);
         WAVE_SAW:    v = (65536 * p) / TABLE_LEN - 32768;
         WAVE_SQUARE: v = (p < HALF_LEN) ? 32767 : -32768;
         default: begin
            if (p < HALF_LEN)
               v = (131072 * p) / TABLE_LEN - 32768;
            else
               v = 98304 - (131072 * p) / TABLE_LEN;
         end
      endcase
      return clamp(v, -32768, 32767);
   endfunction

   function automatic void restore_defaults();
      wave_sel  = WAVE_SINE;
      step_size = 1;
      vol_q15   = UNITY_Q15;
      feed[0]   = 16384;
      feed[1]   = 0;
      feed[2]   = 0;
      back[0]   = 0;
      back[1]   = 0;
      phase     = 0;
      x_d1      = 0;
      x_d2      = 0;
      y_d1      = 0;
      y_d2      = 0;
   endfunction

   // Mirror a register write; bits above each register's width drop out.
   function automatic void shadow_csr(reg_index_type r, logic [15:0] val);
      case (r)
         REG_WAVEFORM_SELECT: wave_sel  = wave_type'(val[SEL_W-1:0]);
         REG_PHASE_STEP:      step_size = int'(val[STEP_W-1:0]);
         REG_VOLUME:          vol_q15   = val;
         REG_FEED_COEF_0:     feed[0]   = longint'(signed'(val));
         REG_FEED_COEF_1:     feed[1]   = longint'(signed'(val));
         REG_FEED_COEF_2:     feed[2]   = longint'(signed'(val));
         REG_BACK_COEF_1:     back[0]   = longint'(signed'(val));
         REG_BACK_COEF_2:     back[1]   = longint'(signed'(val));
         default: ;
      endcase
   endfunction

   // One sample tick: table read, biquad, volume/envelope scaling, phase step.
   function automatic tone_beat_type synth_tick(logic [15:0] env, logic last);
      longint          x, acc, y, scaled;
      longint unsigned vol, env_sat, mag, prod;
      tone_beat_type   beat;
      x   = wave_lookup(wave_sel, phase);
      acc = feed[0] * x + feed[1] * x_d1 + feed[2] * x_d2
          - back[0] * y_d1 - back[1] * y_d2;
      // round half up to Q3.15, then saturate to 18 bits
      y   = clamp((acc + 8192) >>> 14, -131072, 131071);

      // gains above unity clip to unity
      vol     = (vol_q15 > UNITY_Q15) ? 64'd32768 : 64'(vol_q15);
      env_sat = (env > UNITY_Q15) ? 64'd32768 : 64'(env);
      mag     = (y < 0) ? 64'(-y) : 64'(y);
      prod    = (mag * (vol * env_sat) * 64'd32767) >> 45;
      scaled  = (y < 0) ? -longint'(prod) : longint'(prod);
      scaled  = clamp(scaled, -32768, 32767);

      beat.sample = scaled[15:0];
      beat.last   = last;

      y_d2  = y_d1;
      y_d1  = y;
      x_d2  = x_d1;
      x_d1  = x;
      phase = (phase + step_size) % TABLE_LEN;
      return beat;
   endfunction

   // ---------------------------------------------------------------------
   // Stimulus helpers (all entered and left at a falling edge)
   // ---------------------------------------------------------------------

   // Mostly back-to-back, some short gaps, a few long ones; none while calm.
   function automatic int unsigned pick_gap();
      int unsigned r;
      if (calm)
         return 0;
      r = $urandom_range(0, 99);
      if (r < 55)
         return 0;
      if (r < 90)
         return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic void add_tick(logic [15:0] env, logic last, bit typed,
                                    logic [15:0] want);
      stim_row_type row;
      row.kind    = ROW_TICK;
      row.reg_sel = REG_WAVEFORM_SELECT;
      row.value   = env;
      row.last    = last;
      row.typed   = typed;
      row.want    = want;
      script.push_back(row);
   endfunction

   function automatic void add_csr(reg_index_type r, logic [15:0] val);
      stim_row_type row;
      row.kind    = ROW_CSR;
      row.reg_sel = r;
      row.value   = val;
      row.last    = 1'b0;
      row.typed   = 1'b0;
      row.want    = '0;
      script.push_back(row);
   endfunction

   // Offer one tick, hold it until accepted, then queue its expected sample.
   task automatic send_tick(logic [15:0] env, logic last, bit typed,
                            logic [15:0] want);
      int unsigned   gap;
      tone_beat_type beat;
      gap = pick_gap();
      repeat (gap) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= env;
      req_tlast  <= last;
      do @(posedge clock); while (!req_tready);
      beat = synth_tick(env, last);
      if (typed)
         beat.sample = want;
      expected_samples.push_back(beat);
      @(negedge clock);
   endtask

   // Drop valid and wait for every outstanding sample to drain.
   task automatic settle();
      req_tvalid <= 1'b0;
      while (expected_samples.size() != 0)
         @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_csr(reg_index_type r, logic [15:0] val);
      csr_we    <= 1'b1;
      csr_index <= r;
      csr_wdata <= val;
      shadow_csr(r, val);
      @(negedge clock);
      csr_we    <= 1'b0;
      @(negedge clock);
   endtask

   // ---------------------------------------------------------------------
   // Main sequence
   // ---------------------------------------------------------------------

   initial begin
      int unsigned   sent;
      int unsigned   seg;
      int unsigned   burst;
      int unsigned   writes;
      reg_index_type r;
      logic [15:0]   v;
      logic [15:0]   env;

      reset      = 1'b1;
      csr_we     = 1'b0;
      csr_index  = '0;
      csr_wdata  = '0;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tlast  = 1'b0;
      calm       = 1'b0;
      squeeze_pending = 1'b0;
      fail_count = 0;
      restore_defaults();

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Reset state: sine at phase zero is zero, unity filter and gain.
      add_tick(16'd32768, 1'b0, 1'b1, 16'd0);
      add_tick(16'd0,     1'b1, 1'b1, 16'd0);    // zero envelope mutes
      add_tick(16'hFFFF,  1'b0, 1'b0, '0);       // envelope above unity clips
      add_tick(16'd32769, 1'b1, 1'b0, '0);
      // Square with junk in the upper bits, frozen phase.
      add_csr(REG_WAVEFORM_SELECT, 16'hFFFE);
      add_csr(REG_PHASE_STEP, 16'd0);
      add_tick(16'd32768, 1'b0, 1'b0, '0);
      add_tick(16'd1,     1'b1, 1'b0, '0);
      add_csr(REG_VOLUME, 16'd0);
      add_tick(16'd32768, 1'b0, 1'b1, 16'd0);    // zero volume mutes
      // Drive the filter into its saturation rails.
      add_csr(REG_VOLUME, 16'hFFFF);
      add_csr(REG_FEED_COEF_0, 16'h7FFF);
      add_csr(REG_FEED_COEF_1, 16'h7FFF);
      add_csr(REG_FEED_COEF_2, 16'h7FFF);
      add_csr(REG_BACK_COEF_1, 16'h8000);
      add_csr(REG_BACK_COEF_2, 16'h8000);
      repeat (4) add_tick(16'hFFFF, 1'b0, 1'b0, '0);
      // Saw, widest step (upper bits ignored), opposite coefficient extremes.
      add_csr(REG_WAVEFORM_SELECT, 16'd1);
      add_csr(REG_PHASE_STEP, 16'hFFFF);
      add_csr(REG_FEED_COEF_0, 16'h8000);
      add_csr(REG_BACK_COEF_1, 16'h7FFF);
      add_csr(REG_BACK_COEF_2, 16'h7FFF);
      repeat (4) add_tick(16'd32768, 1'b1, 1'b0, '0);
      // Triangle, a step just under half the table lands on both halves.
      add_csr(REG_WAVEFORM_SELECT, 16'd3);
      add_csr(REG_PHASE_STEP, 16'd511);
      add_csr(REG_FEED_COEF_0, 16'd16384);
      add_csr(REG_FEED_COEF_1, 16'd0);
      add_csr(REG_FEED_COEF_2, 16'd0);
      add_csr(REG_BACK_COEF_1, 16'd0);
      add_csr(REG_BACK_COEF_2, 16'd0);
      add_csr(REG_VOLUME, 16'd32768);
      repeat (4) add_tick(16'd32768, 1'b0, 1'b0, '0);
      // Sine again with an odd step that crosses the phase wrap.
      add_csr(REG_WAVEFORM_SELECT, 16'd0);
      add_csr(REG_PHASE_STEP, 16'd37);
      repeat (3) add_tick(16'd20000, 1'b1, 1'b0, '0);

      foreach (script[i]) begin
         if (script[i].kind == ROW_CSR) begin
            settle();
            write_csr(script[i].reg_sel, script[i].value);
         end else begin
            send_tick(script[i].value, script[i].last, script[i].typed, script[i].want);
         end
      end

      // Random part: reconfigure while idle, then a burst of ticks.
      sent = 0;
      seg  = 0;
      while (sent < RANDOM_TICKS) begin
         settle();
         // Often load a stable filter so the output stays off the rails.
         if ($urandom_range(0, 9) < 4) begin
            write_csr(REG_FEED_COEF_0, 16'($urandom_range(0, 16384)));
            write_csr(REG_FEED_COEF_1, 16'(int'($urandom_range(0, 16384)) - 8192));
            write_csr(REG_FEED_COEF_2, 16'(int'($urandom_range(0, 8192)) - 4096));
            write_csr(REG_BACK_COEF_1, 16'(int'($urandom_range(0, 16384)) - 8192));
            write_csr(REG_BACK_COEF_2, 16'($urandom_range(0, 8192)));
         end
         writes = $urandom_range(1, 4);
         repeat (writes) begin
            r = reg_index_type'(3'($urandom_range(0, 7)));
            case (r)
               REG_WAVEFORM_SELECT: v = 16'($urandom());
               REG_PHASE_STEP: begin
                  case ($urandom_range(0, 5))
                     0: v = 16'd0;
                     1: v = 16'd1;
                     2: v = 16'd1023;
                     3: v = 16'd512;
                     default: v = 16'($urandom());
                  endcase
               end
               REG_VOLUME: begin
                  case ($urandom_range(0, 5))
                     0: v = 16'd32768;
                     1: v = 16'd0;
                     2: v = 16'($urandom_range(32769, 65535));
                     default: v = 16'($urandom_range(0, 32768));
                  endcase
               end
               default: begin
                  case ($urandom_range(0, 9))
                     0: v = 16'h8000;
                     1: v = 16'h7FFF;
                     2, 3, 4: v = 16'($urandom());
                     default: v = 16'(int'($urandom_range(0, 16384)) - 8192);
                  endcase
               end
            endcase
            write_csr(r, v);
         end

         // First burst runs calm against a long receiver hold-off so the
         // block backs up and stalls its input.
         calm = (seg % 3 == 0);
         if (seg == 0)
            squeeze_pending = 1'b1;
         burst = $urandom_range(20, 40);
         repeat (burst) begin
            case ($urandom_range(0, 9))
               0: env = 16'd0;
               1: env = 16'd32768;
               2: env = 16'($urandom_range(32769, 65535));
               default: env = 16'($urandom());
            endcase
            send_tick(env, 1'($urandom_range(0, 1)), 1'b0, '0);
            sent++;
         end
         seg++;
      end
      calm = 1'b0;

      // Drain, then give stray beats a chance to show up.
      req_tvalid <= 1'b0;
      while (expected_samples.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (fail_count == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

   // ---------------------------------------------------------------------
   // Receiver: random back-pressure plus one long hold-off on request
   // ---------------------------------------------------------------------

   initial begin
      int unsigned hold_left;
      int unsigned stall_left;
      hold_left  = 0;
      stall_left = 0;
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_left == 0 && squeeze_pending) begin
            squeeze_pending = 1'b0;
            hold_left       = SQUEEZE_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
            if ($urandom_range(0, 9) < 3)
               stall_left = pick_gap();
         end
      end
   end

   // ---------------------------------------------------------------------
   // Checker: compare each delivered sample against the oldest expectation
   // ---------------------------------------------------------------------

   always @(posedge clock) begin : check_samples
      tone_beat_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_samples.size() == 0) begin
            $display("%0t: unexpected sample: sample_out=%0d sample_last=%0b",
                     $time, $signed(rsp_tdata), rsp_tlast);
            fail_count++;
         end else begin
            want = expected_samples.pop_front();
            if (rsp_tdata !== want.sample) begin
               $display("%0t: sample_out mismatch: expected %0d, got %0d",
                        $time, $signed(want.sample), $signed(rsp_tdata));
               fail_count++;
            end
            if (rsp_tlast !== want.last) begin
               $display("%0t: sample_last mismatch: expected %0b, got %0b",
                        $time, want.last, rsp_tlast);
               fail_count++;
            end
         end
      end
   end

   // Watchdog: stop a hung run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > RUN_LIMIT) begin
         $display("%0t: timeout after %0d cycles", $time, cycle_count);
         $display("CHECKS FAILED");
         $finish;
      end
   end

   initial cycle_count = 0;

endmodule

>>> files.f
rtl/wob_pkg.sv
rtl/wob_ctrl.sv
rtl/wob_datapath.sv
rtl/wavetable_oscillator_biquad.sv
dv/tb.sv
